// File: rtl/cplc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cplc_pkg: shared types and constants of the coolant pump level controller
// Holds the event codes, register indexes, configuration, item and result structs.
// ---------------------------------------------------------------------------
package cplc_pkg;

   // Power-off delay after the level drops to zero, in ticks
   localparam int OFF_DELAY_TICKS = 5000;
   localparam int OFF_DELAY_W     = 13;
   // Width of the saturating dwell counter
   localparam int DWELL_W         = 32;

   // Fixed duty values and the forced high level
   localparam logic [6:0] PWM_LEVEL0 = 7'd5;
   localparam logic [6:0] PWM_MAX    = 7'd100;
   localparam logic [1:0] LEVEL_HIGH = 2'd3;

   // Port widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // Event codes carried in req_tuser
   typedef enum logic [2:0] {
      FUNC_TICK       = 3'd0,
      FUNC_CIRC       = 3'd1,
      FUNC_FORCE_HIGH = 3'd2,
      FUNC_MANUAL     = 3'd3,
      FUNC_OFF        = 3'd4
   } func_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COOL_LIMIT   = 4'd0,
      REG_HEAT_LIMIT   = 4'd1,
      REG_START_SPREAD = 4'd2,
      REG_STOP_SPREAD  = 4'd3,
      REG_LOW_DUTY     = 4'd4,
      REG_MIDDLE_DUTY  = 4'd5,
      REG_HIGH_DUTY    = 4'd6,
      REG_DWELL_TICKS  = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] cool_limit;
      logic [15:0] heat_limit;
      logic [15:0] start_spread;
      logic [15:0] stop_spread;
      logic [7:0]  low_duty;
      logic [7:0]  middle_duty;
      logic [7:0]  high_duty;
      logic [31:0] dwell_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] temp_min;
      logic [15:0] temp_max;
      logic [1:0]  manual_level;
      logic        pump_error;
      logic        link_fault;
   } item_type;

   typedef struct packed {
      logic [1:0] pump_level;
      logic [6:0] pwm_duty;
      logic [7:0] reported_duty;
      logic       power_enable;
      logic       run_state;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/cplc_csr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cplc_csr: configuration registers
// Takes register writes by index; indexes beyond the list are dropped.
// ---------------------------------------------------------------------------
module cplc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cplc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cplc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output cplc_pkg::cfg_type                       cfg
);

   cplc_pkg::cfg_type cfg_ff;
   cplc_pkg::cfg_type cfg_in;

   // Writes never stall
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            cplc_pkg::REG_COOL_LIMIT:   cfg_in.cool_limit   = csr_wdata[15:0];
            cplc_pkg::REG_HEAT_LIMIT:   cfg_in.heat_limit   = csr_wdata[15:0];
            cplc_pkg::REG_START_SPREAD: cfg_in.start_spread = csr_wdata[15:0];
            cplc_pkg::REG_STOP_SPREAD:  cfg_in.stop_spread  = csr_wdata[15:0];
            cplc_pkg::REG_LOW_DUTY:     cfg_in.low_duty     = csr_wdata[7:0];
            cplc_pkg::REG_MIDDLE_DUTY:  cfg_in.middle_duty  = csr_wdata[7:0];
            cplc_pkg::REG_HIGH_DUTY:    cfg_in.high_duty    = csr_wdata[7:0];
            cplc_pkg::REG_DWELL_TICKS:  cfg_in.dwell_ticks  = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cplc_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cplc_core: pump level state and per-event update
// Holds the level, dwell and off-delay state; computes the next state and
// the result word for the item presented, and commits it on fire.
// ---------------------------------------------------------------------------
module cplc_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire cplc_pkg::item_type  item,
   input  wire cplc_pkg::cfg_type   cfg,
   output cplc_pkg::result_type     result
);

   localparam logic [cplc_pkg::DWELL_W-1:0] DwellMax = '1;
   localparam logic [cplc_pkg::OFF_DELAY_W-1:0] OffDelayLoad =
      cplc_pkg::OFF_DELAY_W'(cplc_pkg::OFF_DELAY_TICKS);

   logic [1:0]                        level_ff, level_in;
   logic [1:0]                        circ_ff, circ_in;
   logic [cplc_pkg::DWELL_W-1:0]      elapsed_ff, elapsed_in;
   logic                              armed_ff, armed_in;
   logic [cplc_pkg::OFF_DELAY_W-1:0]  left_ff, left_in;
   logic                              running_ff, running_in;
   logic                              power_ff, power_in;
   logic [6:0]                        duty_ff, duty_in;
   logic                              fault_ff, fault_in;

   logic [15:0]                       spread;
   logic [1:0]                        circ_lv;
   logic                              hold;
   logic                              do_apply;
   logic [1:0]                        apply_lv;
   logic [7:0]                        apply_duty;
   logic [cplc_pkg::OFF_DELAY_W-1:0]  left_dec;

   // Configured duty of a level, zero for level zero
   function automatic logic [7:0] level_duty(input cplc_pkg::cfg_type c,
                                             input logic [1:0] lv);
      logic [7:0] d;
      case (lv)
         2'd1:    d = c.low_duty;
         2'd2:    d = c.middle_duty;
         2'd3:    d = c.high_duty;
         default: d = 8'd0;
      endcase
      return d;
   endfunction

   // Circulation level from the sample, later rules win
   always_comb begin
      spread  = item.temp_max - item.temp_min;
      circ_lv = circ_ff;
      if (spread >= cfg.start_spread) begin
         circ_lv = 2'd1;
      end
      if (item.temp_max >= cfg.cool_limit || item.temp_min <= cfg.heat_limit) begin
         circ_lv = 2'd2;
      end
      if (spread <= cfg.stop_spread && item.temp_max < cfg.cool_limit &&
          item.temp_min > cfg.heat_limit) begin
         circ_lv = 2'd0;
      end
      if (item.link_fault) begin
         circ_lv = 2'd1;
      end
      if (item.pump_error) begin
         circ_lv = 2'd0;
      end
      hold = armed_ff && (32'(elapsed_ff) < cfg.dwell_ticks) && !item.pump_error;
   end

   // Event dispatch, then apply the chosen level
   always_comb begin
      level_in   = level_ff;
      circ_in    = circ_ff;
      elapsed_in = elapsed_ff;
      armed_in   = armed_ff;
      left_in    = left_ff;
      running_in = running_ff;
      power_in   = power_ff;
      duty_in    = duty_ff;
      fault_in   = fault_ff;
      do_apply   = 1'b0;
      apply_lv   = 2'd0;
      left_dec   = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

      case (item.func)
         cplc_pkg::FUNC_TICK: begin
            if (elapsed_ff != DwellMax) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            if (running_ff) begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  running_in = 1'b0;
                  power_in   = 1'b0;
               end
            end
         end
         cplc_pkg::FUNC_CIRC: begin
            circ_in  = circ_lv;
            fault_in = item.pump_error;
            if (!hold && level_ff != circ_lv) begin
               do_apply   = 1'b1;
               apply_lv   = circ_lv;
               armed_in   = 1'b1;
               elapsed_in = '0;
            end
         end
         cplc_pkg::FUNC_FORCE_HIGH: begin
            if (item.pump_error) begin
               do_apply = 1'b1;
               apply_lv = 2'd0;
            end else if (level_ff != cplc_pkg::LEVEL_HIGH) begin
               do_apply = 1'b1;
               apply_lv = cplc_pkg::LEVEL_HIGH;
            end
         end
         cplc_pkg::FUNC_MANUAL: begin
            do_apply = 1'b1;
            apply_lv = item.pump_error ? 2'd0 : item.manual_level;
         end
         cplc_pkg::FUNC_OFF: begin
            if (level_ff != 2'd0) begin
               do_apply = 1'b1;
               apply_lv = 2'd0;
            end
         end
         default: ;
      endcase

      apply_duty = level_duty(cfg, apply_lv);

      // Level change: zero starts the off-delay, nonzero powers up
      if (do_apply) begin
         level_in = apply_lv;
         if (apply_lv == 2'd0) begin
            duty_in = cplc_pkg::PWM_LEVEL0;
            if (!running_ff && power_ff) begin
               running_in = 1'b1;
               left_in    = OffDelayLoad;
            end
         end else begin
            duty_in    = (apply_duty > 8'(cplc_pkg::PWM_MAX)) ?
                         cplc_pkg::PWM_MAX : apply_duty[6:0];
            power_in   = 1'b1;
            running_in = 1'b0;
            left_in    = '0;
         end
      end

      result.pump_level    = level_in;
      result.pwm_duty      = duty_in;
      result.reported_duty = level_duty(cfg, level_in);
      result.power_enable  = power_in;
      result.run_state     = fault_in;
   end

   // Commit state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         circ_ff    <= '0;
         elapsed_ff <= '0;
         armed_ff   <= 1'b0;
         left_ff    <= '0;
         running_ff <= 1'b0;
         power_ff   <= 1'b0;
         duty_ff    <= '0;
         fault_ff   <= 1'b0;
      end else if (fire) begin
         level_ff   <= level_in;
         circ_ff    <= circ_in;
         elapsed_ff <= elapsed_in;
         armed_ff   <= armed_in;
         left_ff    <= left_in;
         running_ff <= running_in;
         power_ff   <= power_in;
         duty_ff    <= duty_in;
         fault_ff   <= fault_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/coolant_pump_level_controller_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// coolant_pump_level_controller_unit: coolant pump level controller
// Turns tick, sample and command words into pump level and PWM duty words.
// ---------------------------------------------------------------------------
// Every input word yields exactly one result word. A word passes through an
// input register, then the level update runs combinationally between that
// register and the result register. A new word can be taken every
// cycle while no result is held back by rsp_tready. The only stall comes
// from rsp_tready: a held result blocks the input register, which in turn
// drops req_tready. Configuration writes are never stalled and must be made
// while no word is in flight.
module coolant_pump_level_controller_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: temp_min[15:0], temp_max[31:16], manual_level[33:32],
   //        pump_error[34], link_fault[35], zero[39:36]
   input  wire logic [cplc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: func[2:0]
   input  wire logic [2:0]                          req_tuser,
   // Result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: pump_level[1:0], pwm_duty[8:2], reported_duty[16:9],
   //        power_enable[17], run_state[18], zero[23:19]
   output logic [cplc_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // Configuration port
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cplc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cplc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cplc_pkg::cfg_type     cfg;
   cplc_pkg::item_type    item_ff, item_in;
   cplc_pkg::result_type  result;
   cplc_pkg::result_type  rsp_ff;
   logic                  item_valid_ff, item_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;
   logic                  req_fire;

   cplc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the input word to the result when the result register is free
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   cplc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Unpack the input word
   always_comb begin
      item_in.func         = req_tuser;
      item_in.temp_min     = req_tdata[15:0];
      item_in.temp_max     = req_tdata[31:16];
      item_in.manual_level = req_tdata[33:32];
      item_in.pump_error   = req_tdata[34];
      item_in.link_fault   = req_tdata[35];
      item_valid_in        = req_fire || (item_valid_ff && !advance);
      rsp_valid_in         = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   // Pack the result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.run_state, rsp_ff.power_enable,
                        rsp_ff.reported_duty, rsp_ff.pwm_duty, rsp_ff.pump_level};

   // Driven duty never exceeds full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.pwm_duty <= cplc_pkg::PWM_MAX))
      else $error("pwm duty above 100");

   // A running level always has the pump powered
   a_level_power: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pump_level != 2'd0) |-> rsp_ff.power_enable)
      else $error("nonzero level without pump power");

   // A blocked input word stays in its register
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("input word lost while result stalled");

   // A result is loaded only from a held input word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> $past(item_valid_ff))
      else $error("result without input word");

endmodule

`default_nettype wire

// File: tb/tb_coolant_pump_level_controller_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_coolant_pump_level_controller_unit: pump level controller testbench
// Streams tick, sample and command words through the controller with random
// gaps and stalls on both channels. Each accepted word runs through a local
// pump model whose expected result words are compared field by field with
// the result channel. Several register settings are used, extremes included.
// ---------------------------------------------------------------------------
module tb_coolant_pump_level_controller_unit;
   import cplc_pkg::*;

   localparam int CYCLE_LIMIT      = 3_000_000;
   localparam int RAND_PER_SETTING = 340;
   localparam int TAIL_CYCLES      = 8;
   localparam int SQUEEZE_CYCLES   = 80;
   localparam int SQUEEZE_PERIOD   = 1500;
   localparam int MAX_REPORTS      = 10;
   // Event codes and register indexes with no meaning in the block
   localparam int FUNC_SPARE_MIN   = int'(FUNC_OFF) + 1;
   localparam int FUNC_SPARE_MAX   = (1 << $bits(func_type)) - 1;
   localparam int REG_SPARE_MIN    = int'(REG_DWELL_TICKS) + 1;
   localparam int REG_SPARE_MAX    = (1 << CSR_IDX_W) - 1;
   // Pump levels below the forced high level
   localparam logic [1:0] LVL_IDLE = 2'd0;
   localparam logic [1:0] LVL_LOW  = 2'd1;
   localparam logic [1:0] LVL_MID  = 2'd2;

   logic clock;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [2:0]            req_tuser  = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   coolant_pump_level_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Pump model state and its copy of the registers
   cfg_type                cfg = '0;
   logic [1:0]             lvl_now = '0;
   logic [1:0]             circ_lvl = '0;
   logic [DWELL_W-1:0]     dwell_cnt = '0;
   logic                   dwell_on = 1'b0;
   logic [OFF_DELAY_W-1:0] offdly_left = '0;
   logic                   offdly_on = 1'b0;
   logic                   pwr_on = 1'b0;
   logic [6:0]             duty_now = '0;
   logic                   fault_now = 1'b0;

   item_type   pending_q[$];
   result_type level_expect_q[$];
   item_type   on_bus = '0;
   int         queued = 0;
   int         accepted = 0;
   int         results_seen = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         gap_left = 0;
   int         steady_left = 0;
   int         ready_left = 0;
   int         squeeze_left = 0;
   int         squeeze_mark = 30;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Configured duty of a level, zero for the idle level
   function automatic logic [7:0] duty_of(input logic [1:0] lv);
      case (lv)
         LVL_LOW:    return cfg.low_duty;
         LVL_MID:    return cfg.middle_duty;
         LEVEL_HIGH: return cfg.high_duty;
         default:    return 8'd0;
      endcase
   endfunction

   // Move the pump to a level: set PWM, power and the off delay
   function automatic void set_level(input logic [1:0] lv);
      logic [7:0] d;
      lvl_now = lv;
      if (lv == LVL_IDLE) begin
         duty_now = PWM_LEVEL0;
         if (!offdly_on && pwr_on) begin
            offdly_on   = 1'b1;
            offdly_left = OFF_DELAY_W'(OFF_DELAY_TICKS);
         end
      end else begin
         d           = duty_of(lv);
         duty_now    = (d > 8'(PWM_MAX)) ? PWM_MAX : d[6:0];
         pwr_on      = 1'b1;
         offdly_on   = 1'b0;
         offdly_left = '0;
      end
   endfunction

   // Apply one input word to the pump model and return its result word
   function automatic result_type pump_predict(input item_type it);
      result_type res;
      logic [15:0] spread;
      logic [1:0]  lv;
      case (it.func)
         FUNC_TICK: begin
            if (dwell_cnt != '1) dwell_cnt++;
            if (offdly_on) begin
               if (offdly_left != '0) offdly_left--;
               if (offdly_left == '0) begin
                  offdly_on = 1'b0;
                  pwr_on    = 1'b0;
               end
            end
         end
         FUNC_CIRC: begin
            // later rules override earlier ones
            spread = it.temp_max - it.temp_min;
            lv     = circ_lvl;
            if (spread >= cfg.start_spread) lv = LVL_LOW;
            if (it.temp_max >= cfg.cool_limit || it.temp_min <= cfg.heat_limit) lv = LVL_MID;
            if (spread <= cfg.stop_spread && it.temp_max < cfg.cool_limit &&
                it.temp_min > cfg.heat_limit) lv = LVL_IDLE;
            if (it.link_fault) lv = LVL_LOW;
            if (it.pump_error) lv = LVL_IDLE;
            circ_lvl  = lv;
            fault_now = it.pump_error;
            // hold off during dwell unless the pump is in error
            if (!(dwell_on && dwell_cnt < cfg.dwell_ticks && !it.pump_error) &&
                lvl_now != lv) begin
               set_level(lv);
               dwell_on  = 1'b1;
               dwell_cnt = '0;
            end
         end
         FUNC_FORCE_HIGH: begin
            if (it.pump_error) set_level(LVL_IDLE);
            else if (lvl_now != LEVEL_HIGH) set_level(LEVEL_HIGH);
         end
         FUNC_MANUAL: set_level(it.pump_error ? LVL_IDLE : it.manual_level);
         FUNC_OFF: begin
            if (lvl_now != LVL_IDLE) set_level(LVL_IDLE);
         end
         default: ;
      endcase
      res.pump_level    = lvl_now;
      res.pwm_duty      = duty_now;
      res.reported_duty = duty_of(lvl_now);
      res.power_enable  = pwr_on;
      res.run_state     = fault_now;
      return res;
   endfunction

   function automatic void flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
   endfunction

   function automatic void compare_result(input result_type want, input result_type got);
      if (want.pump_level !== got.pump_level)
         flag_mismatch("pump_level", want.pump_level, got.pump_level);
      if (want.pwm_duty !== got.pwm_duty)
         flag_mismatch("pwm_duty", want.pwm_duty, got.pwm_duty);
      if (want.reported_duty !== got.reported_duty)
         flag_mismatch("reported_duty", want.reported_duty, got.reported_duty);
      if (want.power_enable !== got.power_enable)
         flag_mismatch("power_enable", want.power_enable, got.power_enable);
      if (want.run_state !== got.run_state)
         flag_mismatch("run_state", want.run_state, got.run_state);
   endfunction

   function automatic logic [15:0] near16(input logic [15:0] center);
      return center + 16'($urandom_range(0, 8)) - 16'd4;
   endfunction

   // Random word with temperatures mostly clustered around the configured thresholds
   function automatic item_type rand_item();
      item_type it;
      int r;
      int room;
      it = '0;
      r  = $urandom_range(0, 99);
      if (r < 38)      it.func = FUNC_TICK;
      else if (r < 72) it.func = FUNC_CIRC;
      else if (r < 80) it.func = FUNC_FORCE_HIGH;
      else if (r < 89) it.func = FUNC_MANUAL;
      else if (r < 97) it.func = FUNC_OFF;
      else             it.func = 3'($urandom_range(FUNC_SPARE_MIN, FUNC_SPARE_MAX));
      it.manual_level = 2'($urandom_range(0, 3));
      it.pump_error   = ($urandom_range(0, 99) < 8);
      it.link_fault   = ($urandom_range(0, 99) < 12);
      room = int'(cfg.cool_limit) - int'(cfg.heat_limit);
      case ($urandom_range(0, 4))
         0: begin
            it.temp_min = 16'($urandom);
            it.temp_max = 16'($urandom);
         end
         1: begin
            it.temp_min = near16(cfg.heat_limit);
            it.temp_max = it.temp_min + near16(cfg.start_spread);
         end
         2: begin
            it.temp_min = near16(cfg.heat_limit);
            it.temp_max = near16(cfg.cool_limit);
         end
         default: begin
            // inside both limits, spread near one of the thresholds
            it.temp_min = cfg.heat_limit + 16'((room > 2) ? $urandom_range(1, room - 1) : 1);
            it.temp_max = it.temp_min +
                          near16($urandom_range(0, 1) ? cfg.stop_spread : cfg.start_spread);
         end
      endcase
      return it;
   endfunction

   task automatic add_item(input logic [2:0] f, input logic [15:0] tmin,
                           input logic [15:0] tmax, input logic [1:0] man,
                           input logic err, input logic link);
      item_type it;
      it.func         = f;
      it.temp_min     = tmin;
      it.temp_max     = tmax;
      it.manual_level = man;
      it.pump_error   = err;
      it.link_fault   = link;
      pending_q.push_back(it);
      queued++;
   endtask

   // Wait until every word is through and let the pipeline go quiet
   task automatic settle_pipeline();
      while (accepted != queued || level_expect_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         REG_COOL_LIMIT:   cfg.cool_limit   = val[15:0];
         REG_HEAT_LIMIT:   cfg.heat_limit   = val[15:0];
         REG_START_SPREAD: cfg.start_spread = val[15:0];
         REG_STOP_SPREAD:  cfg.stop_spread  = val[15:0];
         REG_LOW_DUTY:     cfg.low_duty     = val[7:0];
         REG_MIDDLE_DUTY:  cfg.middle_duty  = val[7:0];
         REG_HIGH_DUTY:    cfg.high_duty    = val[7:0];
         REG_DWELL_TICKS:  cfg.dwell_ticks  = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(REG_COOL_LIMIT, 32'(c.cool_limit));
      write_reg(REG_HEAT_LIMIT, 32'(c.heat_limit));
      write_reg(REG_START_SPREAD, 32'(c.start_spread));
      write_reg(REG_STOP_SPREAD, 32'(c.stop_spread));
      write_reg(REG_LOW_DUTY, 32'(c.low_duty));
      write_reg(REG_MIDDLE_DUTY, 32'(c.middle_duty));
      write_reg(REG_HIGH_DUTY, 32'(c.high_duty));
      write_reg(REG_DWELL_TICKS, c.dwell_ticks);
   endtask

   task automatic run_random(input int n);
      repeat (n) begin
         pending_q.push_back(rand_item());
         queued++;
      end
      settle_pipeline();
   endtask

   // Input word driver
   always @(posedge clock) begin
      int r;
      if (reset) begin
         req_tvalid  <= 1'b0;
         gap_left    <= 0;
         steady_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            level_expect_q.push_back(pump_predict(on_bus));
            accepted <= accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            // skip gaps while the receiver squeezes, so the block backs up
            if (gap_left != 0 && squeeze_left == 0) begin
               req_tvalid <= 1'b0;
               gap_left   <= gap_left - 1;
            end else if (pending_q.size() != 0) begin
               on_bus = pending_q.pop_front();
               req_tdata  <= REQ_DATA_W'({on_bus.link_fault, on_bus.pump_error,
                                          on_bus.manual_level, on_bus.temp_max,
                                          on_bus.temp_min});
               req_tuser  <= on_bus.func;
               req_tvalid <= 1'b1;
               if (steady_left != 0) begin
                  steady_left <= steady_left - 1;
                  gap_left    <= 0;
               end else begin
                  r = $urandom_range(0, 99);
                  if (r < 55)      gap_left <= 0;
                  else if (r < 85) gap_left <= $urandom_range(1, 3);
                  else if (r < 95) gap_left <= $urandom_range(4, 10);
                  else             gap_left <= $urandom_range(15, 40);
                  if (r == 99) steady_left <= $urandom_range(30, 80);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result ready pattern, with a long hold-off now and then
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_tready   <= 1'b0;
         ready_left   <= 0;
         squeeze_left <= 0;
      end else if (squeeze_left != 0) begin
         rsp_tready   <= 1'b0;
         squeeze_left <= squeeze_left - 1;
      end else if (results_seen >= squeeze_mark) begin
         rsp_tready   <= 1'b0;
         squeeze_left <= SQUEEZE_CYCLES;
         squeeze_mark <= squeeze_mark + SQUEEZE_PERIOD;
      end else if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_tready <= 1'b1;
            ready_left <= $urandom_range(1, 8);
         end else if (r < 80) begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(1, 3);
         end else if (r < 93) begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(6, 20);
         end else if (r < 97) begin
            rsp_tready <= 1'b1;
            ready_left <= $urandom_range(100, 300);
         end else begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(20, 30);
         end
      end
   end

   // Result word checker
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         got.pump_level    = rsp_tdata[1:0];
         got.pwm_duty      = rsp_tdata[8:2];
         got.reported_duty = rsp_tdata[16:9];
         got.power_enable  = rsp_tdata[17];
         got.run_state     = rsp_tdata[18];
         if (level_expect_q.size() == 0)
            flag_mismatch("unexpected result word", 0, int'(rsp_tdata));
         else
            compare_result(level_expect_q.pop_front(), got);
      end
   end

   // Run time limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Test sequence
   initial begin
      cfg_type setting;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // moderate limits, short dwell, high duty above the clamp
      setting              = '0;
      setting.cool_limit   = 16'd3000;
      setting.heat_limit   = 16'd500;
      setting.start_spread = 16'd800;
      setting.stop_spread  = 16'd200;
      setting.low_duty     = 8'd40;
      setting.middle_duty  = 8'd70;
      setting.high_duty    = 8'd150;
      setting.dwell_ticks  = 32'd3;
      load_settings(setting);

      // directed words: every rule, dwell hold, commands, spare codes
      add_item(FUNC_TICK, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_CIRC, 16'd1000, 16'd1100, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_CIRC, 16'd1000, 16'd2000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_CIRC, 16'd1000, 16'd3000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'hFFFF, 16'hFFFF, 2'd3, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_CIRC, 16'd500, 16'd900, 2'd0, 1'b0, 1'b0);
      // spread wraps to one, inside the limits
      add_item(FUNC_CIRC, 16'hFFFF, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_CIRC, 16'd1000, 16'd1100, 2'd0, 1'b0, 1'b1);
      // pump error breaks through the dwell hold
      add_item(FUNC_CIRC, 16'h0000, 16'hFFFF, 2'd3, 1'b1, 1'b1);
      add_item(FUNC_FORCE_HIGH, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_FORCE_HIGH, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_FORCE_HIGH, 16'h0000, 16'h0000, 2'd0, 1'b1, 1'b0);
      add_item(FUNC_MANUAL, 16'h0000, 16'h0000, 2'd1, 1'b0, 1'b0);
      add_item(FUNC_MANUAL, 16'h0000, 16'h0000, 2'd2, 1'b0, 1'b0);
      add_item(FUNC_MANUAL, 16'h0000, 16'h0000, 2'd3, 1'b1, 1'b0);
      add_item(FUNC_MANUAL, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_OFF, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_MANUAL, 16'h0000, 16'h0000, 2'd3, 1'b0, 1'b0);
      add_item(FUNC_OFF, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      // a nonzero level cancels the running off delay
      add_item(FUNC_MANUAL, 16'h0000, 16'h0000, 2'd2, 1'b0, 1'b0);
      add_item(3'(FUNC_SPARE_MIN), 16'h1234, 16'h4321, 2'd1, 1'b1, 1'b1);
      add_item(3'(FUNC_SPARE_MAX), 16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
      settle_pipeline();

      // every register at its maximum; unused indexes must be ignored
      setting = '1;
      load_settings(setting);
      write_reg(CSR_IDX_W'(REG_SPARE_MIN), 32'($urandom));
      write_reg(CSR_IDX_W'(REG_SPARE_MAX), 32'hFFFF_FFFF);
      run_random(RAND_PER_SETTING);

      // every register at zero
      setting = '0;
      load_settings(setting);
      run_random(RAND_PER_SETTING);

      // ordered limits with a short dwell
      setting.heat_limit   = 16'($urandom_range(100, 20000));
      setting.cool_limit   = setting.heat_limit + 16'($urandom_range(50, 20000));
      setting.start_spread = 16'($urandom_range(0, 2000));
      setting.stop_spread  = 16'($urandom_range(0, setting.start_spread));
      setting.low_duty     = 8'($urandom);
      setting.middle_duty  = 8'($urandom);
      setting.high_duty    = 8'($urandom);
      setting.dwell_ticks  = 32'($urandom_range(0, 20));
      load_settings(setting);
      run_random(RAND_PER_SETTING);

      // unordered random limits
      setting.cool_limit   = 16'($urandom);
      setting.heat_limit   = 16'($urandom);
      setting.start_spread = 16'($urandom);
      setting.stop_spread  = 16'($urandom);
      setting.low_duty     = 8'($urandom);
      setting.middle_duty  = 8'($urandom);
      setting.high_duty    = 8'($urandom);
      setting.dwell_ticks  = 32'($urandom_range(0, 5));
      load_settings(setting);
      run_random(RAND_PER_SETTING);

      // back to moderate limits for a last batch
      setting              = '0;
      setting.cool_limit   = 16'd4000;
      setting.heat_limit   = 16'd1000;
      setting.start_spread = 16'd600;
      setting.stop_spread  = 16'd100;
      setting.low_duty     = 8'd30;
      setting.middle_duty  = 8'd100;
      setting.high_duty    = 8'd101;
      setting.dwell_ticks  = 32'd8;
      load_settings(setting);
      run_random(RAND_PER_SETTING);

      if (mismatch_count == 0 && level_expect_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
